[src/rpy_pkg.sv]
// Package: fixed-point coefficients, widths and shared types for the RGB pair to YUYV converter.
`timescale 1ns / 1ps

package rpy_pkg;

    // Fraction bits of the fixed-point coefficients (valid range 10..24)
    localparam int COEF_FRAC_BITS = 16;

    // Every coefficient magnitude is below one, so it fits in the fraction bits
    localparam int COEF_W = COEF_FRAC_BITS;
    // Unsigned product of an 8-bit component and a coefficient
    localparam int PROD_W = COEF_W + 8;
    // Signed sum: covers -1024 up to just under +1024 in integer units
    localparam int SUM_W  = COEF_FRAC_BITS + 11;

    typedef logic [COEF_W-1:0]        t_coef;
    typedef logic [PROD_W-1:0]        t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    // Coefficient from a magnitude in units of 1e-5, rounded to nearest
    function automatic longint coef_of(input longint m);
        return ((m <<< COEF_FRAC_BITS) + 64'sd50000) / 64'sd100000;
    endfunction

    // Integer value moved to the fixed-point grid
    function automatic t_sum to_fx(input longint v);
        return t_sum'(v <<< COEF_FRAC_BITS);
    endfunction

    // Luma coefficients
    localparam t_coef K_Y_R = t_coef'(coef_of(64'sd21260));
    localparam t_coef K_Y_G = t_coef'(coef_of(64'sd71520));
    localparam t_coef K_Y_B = t_coef'(coef_of(64'sd7220));
    // Blue-difference chroma coefficients (magnitudes; R and G subtract)
    localparam t_coef K_U_R = t_coef'(coef_of(64'sd9991));
    localparam t_coef K_U_G = t_coef'(coef_of(64'sd33609));
    localparam t_coef K_U_B = t_coef'(coef_of(64'sd43600));
    // Red-difference chroma coefficients (magnitudes; G and B subtract)
    localparam t_coef K_V_R = t_coef'(coef_of(64'sd61500));
    localparam t_coef K_V_G = t_coef'(coef_of(64'sd55861));
    localparam t_coef K_V_B = t_coef'(coef_of(64'sd5639));

    // Output ranges
    localparam logic [7:0] LUMA_LO   = 8'h10;
    localparam logic [7:0] LUMA_HI   = 8'hF0;
    localparam logic [7:0] CHROMA_LO = 8'h00;
    localparam logic [7:0] CHROMA_HI = 8'hFF;
    localparam longint     CHROMA_OFS = 64'sd128;

    // Range limits and chroma offset on the fixed-point grid
    localparam t_sum LUMA_LO_FX   = to_fx(longint'(LUMA_LO));
    localparam t_sum LUMA_HI_FX   = to_fx(longint'(LUMA_HI));
    localparam t_sum CHROMA_LO_FX = to_fx(longint'(CHROMA_LO));
    localparam t_sum CHROMA_HI_FX = to_fx(longint'(CHROMA_HI));
    localparam t_sum CHROMA_OFS_FX = to_fx(CHROMA_OFS);

    // Per-stage load enables handed from the pipeline control to the datapath
    typedef struct packed {
        logic s1;   // products
        logic s2;   // sums
        logic s3;   // clamp and truncate
    } t_pipe_en;

endpackage

[src/rpy_if.sv]
// Interfaces: valid/ready channels for RGB pixel pairs and YUYV results.
`timescale 1ns / 1ps

// Two adjacent RGB pixels per transaction
interface rpy_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_a;
    logic [7:0] green_a;
    logic [7:0] blue_a;
    logic [7:0] red_b;
    logic [7:0] green_b;
    logic [7:0] blue_b;

    modport source (output valid, output red_a, output green_a, output blue_a,
                    output red_b, output green_b, output blue_b, input ready);
    modport sink   (input valid, input red_a, input green_a, input blue_a,
                    input red_b, input green_b, input blue_b, output ready);
endinterface

// One packed YUYV pair per transaction
interface rpy_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_a;
    logic [7:0] chroma_blue;
    logic [7:0] luma_b;
    logic [7:0] chroma_red;

    modport source (output valid, output luma_a, output chroma_blue,
                    output luma_b, output chroma_red, input ready);
    modport sink   (input valid, input luma_a, input chroma_blue,
                    input luma_b, input chroma_red, output ready);
endinterface

[src/rpy_pixel_conv.sv]
// Module: three-stage RGB to Y/U/V datapath for one pixel (products, sums, clamp).
`timescale 1ns / 1ps

module rpy_pixel_conv (
    input  logic            i_clk,
    input  rpy_pkg::t_pipe_en i_en,
    input  logic [7:0]      i_red,
    input  logic [7:0]      i_green,
    input  logic [7:0]      i_blue,
    output logic [7:0]      o_luma,
    output logic [7:0]      o_cb,
    output logic [7:0]      o_cr
);

    // Stage 1 registers: unsigned products
    rpy_pkg::t_prod r_py_r, r_py_g, r_py_b;
    rpy_pkg::t_prod r_pu_r, r_pu_g, r_pu_b;
    rpy_pkg::t_prod r_pv_r, r_pv_g, r_pv_b;

    // Stage 2 registers: signed fixed-point sums
    rpy_pkg::t_sum r_sy, r_su, r_sv;
    rpy_pkg::t_sum n_sy, n_su, n_sv;

    // Stage 3 registers: clamped integer results
    logic [7:0] r_luma, r_cb, r_cr;
    logic [7:0] n_luma, n_cb, n_cr;

    // Saturate to lo..hi, otherwise drop the fraction bits
    function automatic logic [7:0] clamp_trunc(
        input rpy_pkg::t_sum v,
        input rpy_pkg::t_sum lo_fx,
        input rpy_pkg::t_sum hi_fx,
        input logic [7:0]    lo,
        input logic [7:0]    hi
    );
        logic [7:0] res;
        if (v > hi_fx) begin
            res = hi;
        end else if (v < lo_fx) begin
            res = lo;
        end else begin
            res = v[rpy_pkg::COEF_FRAC_BITS +: 8];
        end
        return res;
    endfunction

    // Stage 1: one multiplier per coefficient
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_py_r <= rpy_pkg::t_prod'(i_red)   * rpy_pkg::t_prod'(rpy_pkg::K_Y_R);
            r_py_g <= rpy_pkg::t_prod'(i_green) * rpy_pkg::t_prod'(rpy_pkg::K_Y_G);
            r_py_b <= rpy_pkg::t_prod'(i_blue)  * rpy_pkg::t_prod'(rpy_pkg::K_Y_B);
            r_pu_r <= rpy_pkg::t_prod'(i_red)   * rpy_pkg::t_prod'(rpy_pkg::K_U_R);
            r_pu_g <= rpy_pkg::t_prod'(i_green) * rpy_pkg::t_prod'(rpy_pkg::K_U_G);
            r_pu_b <= rpy_pkg::t_prod'(i_blue)  * rpy_pkg::t_prod'(rpy_pkg::K_U_B);
            r_pv_r <= rpy_pkg::t_prod'(i_red)   * rpy_pkg::t_prod'(rpy_pkg::K_V_R);
            r_pv_g <= rpy_pkg::t_prod'(i_green) * rpy_pkg::t_prod'(rpy_pkg::K_V_G);
            r_pv_b <= rpy_pkg::t_prod'(i_blue)  * rpy_pkg::t_prod'(rpy_pkg::K_V_B);
        end
    end

    // Stage 2: exact sums, chroma carries the 128 offset
    always_comb begin
        n_sy = rpy_pkg::t_sum'(r_py_r) + rpy_pkg::t_sum'(r_py_g)
             + rpy_pkg::t_sum'(r_py_b);
        n_su = rpy_pkg::CHROMA_OFS_FX - rpy_pkg::t_sum'(r_pu_r)
             - rpy_pkg::t_sum'(r_pu_g) + rpy_pkg::t_sum'(r_pu_b);
        n_sv = rpy_pkg::CHROMA_OFS_FX + rpy_pkg::t_sum'(r_pv_r)
             - rpy_pkg::t_sum'(r_pv_g) - rpy_pkg::t_sum'(r_pv_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_sy <= n_sy;
            r_su <= n_su;
            r_sv <= n_sv;
        end
    end

    // Stage 3: saturate and truncate
    always_comb begin
        n_luma = clamp_trunc(r_sy, rpy_pkg::LUMA_LO_FX, rpy_pkg::LUMA_HI_FX,
                             rpy_pkg::LUMA_LO, rpy_pkg::LUMA_HI);
        n_cb   = clamp_trunc(r_su, rpy_pkg::CHROMA_LO_FX, rpy_pkg::CHROMA_HI_FX,
                             rpy_pkg::CHROMA_LO, rpy_pkg::CHROMA_HI);
        n_cr   = clamp_trunc(r_sv, rpy_pkg::CHROMA_LO_FX, rpy_pkg::CHROMA_HI_FX,
                             rpy_pkg::CHROMA_LO, rpy_pkg::CHROMA_HI);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_luma <= n_luma;
            r_cb   <= n_cb;
            r_cr   <= n_cr;
        end
    end

    assign o_luma = r_luma;
    assign o_cb   = r_cb;
    assign o_cr   = r_cr;

endmodule

[src/rgb_pair_to_yuyv.sv]
// Top level: pipelined RGB pixel pair to packed YUYV 4:2:2 converter.
`timescale 1ns / 1ps
//
// Usage
//   i_pix carries two horizontally adjacent 8-bit RGB pixels per transaction.
//   o_yuv carries one packed YUYV pair: luma of each pixel (16..240) and the
//   floor average of both pixels' U and V (0..255, offset 128).
// Pipeline and throughput
//   Four register stages: products, sums, clamp, chroma average/output.
//   One pixel pair per cycle sustained while o_yuv.ready stays high; each
//   stage holds one transaction and the depth is set by the multiply, sum,
//   clamp and chroma average stages.
// Reset
//   i_rst_n (synchronous, active low) clears all stage valid bits; no
//   results are pending afterwards and i_pix.ready is high.
// Stall
//   When o_yuv.ready is low the output holds; earlier stages keep filling
//   empty slots and i_pix.ready drops only when every stage is occupied.
//   Nothing is lost or repeated.
//
module rgb_pair_to_yuyv (
    input  logic i_clk,
    input  logic i_rst_n,
    rpy_in_if.sink    i_pix,
    rpy_out_if.source o_yuv
);

    // Stage valid bits
    logic r_v1, r_v2, r_v3, r_v4;
    logic en4;
    rpy_pkg::t_pipe_en en;

    // Per-pixel results from stage 3
    logic [7:0] luma_a, cb_a, cr_a;
    logic [7:0] luma_b, cb_b, cr_b;

    // Output registers
    logic [7:0] r_luma_a, r_luma_b, r_chroma_blue, r_chroma_red;
    logic [8:0] n_cb_sum, n_cr_sum;

    // A stage loads when it is empty or its contents move on
    always_comb begin
        en4  = !r_v4 || o_yuv.ready;
        en.s3 = !r_v3 || en4;
        en.s2 = !r_v2 || en.s3;
        en.s1 = !r_v1 || en.s2;
    end

    assign i_pix.ready = en.s1;

    // Valid bits follow the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en.s1) r_v1 <= i_pix.valid;
            if (en.s2) r_v2 <= r_v1;
            if (en.s3) r_v3 <= r_v2;
            if (en4)   r_v4 <= r_v3;
        end
    end

    // Pixel datapaths
    rpy_pixel_conv u_conv_a (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_red   (i_pix.red_a),
        .i_green (i_pix.green_a),
        .i_blue  (i_pix.blue_a),
        .o_luma  (luma_a),
        .o_cb    (cb_a),
        .o_cr    (cr_a)
    );

    rpy_pixel_conv u_conv_b (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_red   (i_pix.red_b),
        .i_green (i_pix.green_b),
        .i_blue  (i_pix.blue_b),
        .o_luma  (luma_b),
        .o_cb    (cb_b),
        .o_cr    (cr_b)
    );

    // Stage 4: floor average of the chroma pair
    always_comb begin
        n_cb_sum = {1'b0, cb_a} + {1'b0, cb_b};
        n_cr_sum = {1'b0, cr_a} + {1'b0, cr_b};
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_luma_a      <= luma_a;
            r_luma_b      <= luma_b;
            r_chroma_blue <= n_cb_sum[8:1];
            r_chroma_red  <= n_cr_sum[8:1];
        end
    end

    assign o_yuv.valid       = r_v4;
    assign o_yuv.luma_a      = r_luma_a;
    assign o_yuv.chroma_blue = r_chroma_blue;
    assign o_yuv.luma_b      = r_luma_b;
    assign o_yuv.chroma_red  = r_chroma_red;

endmodule
